>>> sv/loop_trip_count_calc_defines.svh
// Assertion helpers for the trip-count block.
`ifndef LOOP_TRIP_COUNT_CALC_DEFINES_SVH
`define LOOP_TRIP_COUNT_CALC_DEFINES_SVH

// Implication checked at every clock edge once reset is released.
`define LTC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ltc check failed");

// Next-cycle implication.
`define LTC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ltc check failed");

`endif

>>> sv/ltc_pkg.sv
package ltc_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned StepW = 63;
	localparam int unsigned KindW = 4;
	localparam int unsigned StatW = 2;

	localparam logic [StatW-1:0] ST_OK    = 2'd0;
	localparam logic [StatW-1:0] ST_OVF   = 2'd1;
	localparam logic [StatW-1:0] ST_UNSUP = 2'd2;

	localparam logic [KindW-1:0] KIND_LAST = 4'd7;

	localparam logic [WordW-1:0] SIGN_BIT = {1'b1, {(WordW-1){1'b0}}};
	localparam logic [StepW-1:0] MASK63   = {StepW{1'b1}};

	// side info that rides along with each beat through the pipeline
	typedef struct packed {
		logic [StatW-1:0] status;
		logic             strict;
		logic             empty;
	} meta_t;

endpackage

>>> sv/ltc_prep.sv
module ltc_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [ltc_pkg::WordW-1:0]     start_value,
	input  logic [ltc_pkg::WordW-1:0]     limit_value,
	input  logic [ltc_pkg::WordW-1:0]     limit_offset,
	input  logic [ltc_pkg::StepW-1:0]     step_size,
	input  logic [ltc_pkg::KindW-1:0]     kind,
	output logic                          out_valid,
	output ltc_pkg::meta_t                out_meta,
	output logic [ltc_pkg::StepW-1:0]     out_num,
	output logic [ltc_pkg::StepW-1:0]     out_den
);

	// stage 1: swap / negate
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic [ltc_pkg::WordW-1:0] lim_s1, off_s1, start_s1, start_s2;
	logic [ltc_pkg::StepW-1:0] step_s1, step_s2, step_s3, step_s4;
	ltc_pkg::meta_t            meta_s1, meta_s2, meta_s3, meta_s4;
	logic [ltc_pkg::WordW-1:0] d1_s2;
	logic [ltc_pkg::StepW-1:0] room_s3;
	logic [ltc_pkg::StepW-1:0] num_s4;

	logic                      unsup, desc, neg_ovf;
	logic [ltc_pkg::WordW:0]   d1_x, room_x;
	logic                      ovf1, ovf2;
	logic [ltc_pkg::WordW-1:0] sum_w;

	always_comb begin
		unsup   = (kind > ltc_pkg::KIND_LAST) || (step_size == '0);
		desc    = kind[1];
		neg_ovf = desc && (limit_offset == ltc_pkg::SIGN_BIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lim_s1         <= desc ? start_value : limit_value;
			start_s1       <= desc ? limit_value : start_value;
			off_s1         <= desc ? (~limit_offset + 64'd1) : limit_offset;
			step_s1        <= step_size;
			meta_s1.strict <= ~kind[0];
			meta_s1.empty  <= 1'b0;
			meta_s1.status <= unsup ? ltc_pkg::ST_UNSUP :
			                  neg_ovf ? ltc_pkg::ST_OVF : ltc_pkg::ST_OK;
		end
	end

	// stage 2: limit - offset
	always_comb begin
		d1_x = {lim_s1[ltc_pkg::WordW-1], lim_s1} - {off_s1[ltc_pkg::WordW-1], off_s1};
		ovf1 = d1_x[ltc_pkg::WordW] != d1_x[ltc_pkg::WordW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s2          <= d1_x[ltc_pkg::WordW-1:0];
			start_s2       <= start_s1;
			step_s2        <= step_s1;
			meta_s2.strict <= meta_s1.strict;
			meta_s2.empty  <= meta_s1.empty;
			meta_s2.status <= (meta_s1.status == ltc_pkg::ST_OK && ovf1) ?
			                  ltc_pkg::ST_OVF : meta_s1.status;
		end
	end

	// stage 3: span = (limit - offset) - start
	always_comb begin
		room_x = {d1_s2[ltc_pkg::WordW-1], d1_s2} - {start_s2[ltc_pkg::WordW-1], start_s2};
		ovf2   = room_x[ltc_pkg::WordW] != room_x[ltc_pkg::WordW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	// only a positive span is used downstream, so its sign bit is dropped
	always_ff @(posedge clk) begin
		if (en) begin
			room_s3        <= room_x[ltc_pkg::StepW-1:0];
			step_s3        <= step_s2;
			meta_s3.strict <= meta_s2.strict;
			meta_s3.status <= (meta_s2.status == ltc_pkg::ST_OK && ovf2) ?
			                  ltc_pkg::ST_OVF : meta_s2.status;
			meta_s3.empty  <= meta_s2.empty ||
			                  (meta_s2.status == ltc_pkg::ST_OK && !ovf2 &&
			                   (room_x[ltc_pkg::WordW-1] || room_x[ltc_pkg::WordW-1:0] == '0));
		end
	end

	// stage 4: rounding lift for strict guards
	always_comb begin
		sum_w = {1'b0, room_s3} + {1'b0, step_s3} - 64'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s4        <= step_s3;
			meta_s4.strict <= meta_s3.strict;
			meta_s4.empty  <= meta_s3.empty;
			meta_s4.status <= (meta_s3.status == ltc_pkg::ST_OK && !meta_s3.empty &&
			                   meta_s3.strict && sum_w[ltc_pkg::WordW-1]) ?
			                  ltc_pkg::ST_OVF : meta_s3.status;
			if (meta_s3.status != ltc_pkg::ST_OK || meta_s3.empty) begin
				num_s4 <= '0;
			end else if (meta_s3.strict) begin
				num_s4 <= sum_w[ltc_pkg::StepW-1:0];
			end else begin
				num_s4 <= room_s3;
			end
		end
	end

	assign out_valid = v_s4;
	assign out_meta  = meta_s4;
	assign out_num   = num_s4;
	assign out_den   = step_s4;

endmodule

>>> sv/ltc_div.sv
module ltc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  ltc_pkg::meta_t            in_meta,
	input  logic [ltc_pkg::StepW-1:0] in_num,
	input  logic [ltc_pkg::StepW-1:0] in_den,
	output logic                      out_valid,
	output ltc_pkg::meta_t            out_meta,
	output logic [ltc_pkg::StepW-1:0] out_quo
);

	localparam int unsigned N = ltc_pkg::StepW;

	// one quotient bit per stage, restoring
	logic                 v_s    [N];
	ltc_pkg::meta_t       meta_s [N];
	logic [N-1:0]         rem_s  [N];
	logic [N-1:0]         num_s  [N];
	logic [N-1:0]         den_s  [N];
	logic [N-1:0]         quo_s  [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic                 pv;
		ltc_pkg::meta_t       pmeta;
		logic [N-1:0]         prem, pnum, pden, pquo;
		logic [N:0]           shifted, diff;
		logic                 ge;

		if (i == 0) begin : g_first
			assign pv    = in_valid;
			assign pmeta = in_meta;
			assign prem  = '0;
			assign pnum  = in_num;
			assign pden  = in_den;
			assign pquo  = '0;
		end else begin : g_next
			assign pv    = v_s[i-1];
			assign pmeta = meta_s[i-1];
			assign prem  = rem_s[i-1];
			assign pnum  = num_s[i-1];
			assign pden  = den_s[i-1];
			assign pquo  = quo_s[i-1];
		end

		always_comb begin
			shifted = {prem, pnum[N-1]};
			diff    = shifted - {1'b0, pden};
			ge      = ~diff[N];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[i] <= pmeta;
				rem_s[i]  <= ge ? diff[N-1:0] : shifted[N-1:0];
				num_s[i]  <= {pnum[N-2:0], 1'b0};
				den_s[i]  <= pden;
				quo_s[i]  <= {pquo[N-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_meta  = meta_s[N-1];
	assign out_quo   = quo_s[N-1];

endmodule

>>> sv/loop_trip_count_calc.sv
// Channel | Dir | tdata (low bit up)                                  | tuser
// s_*     | in  | start_value 64, limit_value 64, limit_offset 64,    | kind 4
//         |     | step_size 63, one pad bit (256 bits)                |
// m_*     | out | trip_total 63, one pad bit (64 bits)                | status 2
//
// One beat enters per cycle unless m_tready stalls; it passes 4 prep stages,
// 63 divider stages and the output register. The one-bit-per-stage divider
// chain sets the throughput, taking a new dividend every cycle unless stalled.
// arst_n clears only valid bits; payload registers carry no reset.
// A stall on m_tready freezes the whole pipe in place; s_tready drops with it.
`include "loop_trip_count_calc_defines.svh"

module loop_trip_count_calc (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,   // start_value, limit_value, limit_offset, step_size
	input  logic [3:0]   s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // trip_total
	output logic [1:0]   m_tuser    // status
);

	logic                      en;
	logic                      prep_v, div_v;
	ltc_pkg::meta_t            prep_meta, div_meta;
	logic [ltc_pkg::StepW-1:0] prep_num, prep_den, div_quo;

	logic                      out_v_q;
	logic [ltc_pkg::StepW-1:0] trip_q;
	logic [ltc_pkg::StatW-1:0] stat_q;

	// whole pipe advances whenever the output slot is free or being drained
	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	ltc_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_tvalid),
		.start_value  (s_tdata[63:0]),
		.limit_value  (s_tdata[127:64]),
		.limit_offset (s_tdata[191:128]),
		.step_size    (s_tdata[254:192]),
		.kind         (s_tuser),
		.out_valid    (prep_v),
		.out_meta     (prep_meta),
		.out_num      (prep_num),
		.out_den      (prep_den)
	);

	ltc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_v),
		.in_meta   (prep_meta),
		.in_num    (prep_num),
		.in_den    (prep_den),
		.out_valid (div_v),
		.out_meta  (div_meta),
		.out_quo   (div_quo)
	);

	// final stage: le guards add one, with overflow when quotient is all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (div_meta.status != ltc_pkg::ST_OK) begin
				trip_q <= '0;
				stat_q <= div_meta.status;
			end else if (div_meta.empty) begin
				trip_q <= '0;
				stat_q <= ltc_pkg::ST_OK;
			end else if (div_meta.strict) begin
				trip_q <= div_quo;
				stat_q <= ltc_pkg::ST_OK;
			end else if (div_quo == ltc_pkg::MASK63) begin
				trip_q <= '0;
				stat_q <= ltc_pkg::ST_OVF;
			end else begin
				trip_q <= div_quo + 63'd1;
				stat_q <= ltc_pkg::ST_OK;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, trip_q};
	assign m_tuser  = stat_q;

	`LTC_ASSERT_IMP(a_fail_zero, m_tvalid && m_tuser != ltc_pkg::ST_OK, m_tdata == 64'd0)
	`LTC_ASSERT_IMP(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready))
	`LTC_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

>>> test/loop_trip_count_calc_chk.sv
`timescale 1ns / 100ps

module loop_trip_count_calc_chk (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [255:0] s_tdata,   // start_value, limit_value, limit_offset, step_size
	input  logic [3:0]   s_tuser,   // kind
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,   // trip_total
	input  logic [1:0]   m_tuser,   // status
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic [ltc_pkg::StepW-1:0] trips;
		logic [ltc_pkg::StatW-1:0] status;
	} trip_answer_t;

	trip_answer_t answers_q[$];

	function automatic trip_answer_t count_trips(logic [255:0] d, logic [3:0] k);
		trip_answer_t a;
		logic [63:0] lo, hi, offs, stp, room, tmp, q;
		logic strict;
		lo   = d[63:0];
		hi   = d[127:64];
		offs = d[191:128];
		stp  = {1'b0, d[254:192]};
		a.trips  = '0;
		a.status = ltc_pkg::ST_OK;
		if (k > ltc_pkg::KIND_LAST || stp == 64'd0) begin
			a.status = ltc_pkg::ST_UNSUP;
			return a;
		end
		strict = ~k[0];
		if (k[1]) begin
			tmp = lo; lo = hi; hi = tmp;
			if (offs == ltc_pkg::SIGN_BIT) begin
				a.status = ltc_pkg::ST_OVF;
				return a;
			end
			offs = -offs;
		end
		tmp = hi - offs;
		if (((hi ^ offs) & (hi ^ tmp)) & ltc_pkg::SIGN_BIT) begin
			a.status = ltc_pkg::ST_OVF;
			return a;
		end
		room = tmp - lo;
		if (((tmp ^ lo) & (tmp ^ room)) & ltc_pkg::SIGN_BIT) begin
			a.status = ltc_pkg::ST_OVF;
			return a;
		end
		if (room == 64'd0 || room[63]) return a;
		if (strict) begin
			if (room > {1'b0, ltc_pkg::MASK63} - (stp - 1)) begin
				a.status = ltc_pkg::ST_OVF;
				return a;
			end
			q = (room + stp - 1) / stp;
			a.trips = q[62:0];
		end else begin
			q = room / stp;
			if (q == {1'b0, ltc_pkg::MASK63}) begin
				a.status = ltc_pkg::ST_OVF;
				return a;
			end
			q = q + 1;
			a.trips = q[62:0];
		end
		return a;
	endfunction

	int mismatches;
	assign fail_count = mismatches;
	assign pending = answers_q.size();

	always @(posedge clk or negedge arst_n) begin
		trip_answer_t want;
		if (!arst_n) begin
			mismatches <= 0;
		end else begin
			if (s_tvalid && s_tready)
				answers_q.push_back(count_trips(s_tdata, s_tuser));
			if (m_tvalid && m_tready) begin
				if (answers_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result beat: trips %0d status %0d",
							m_tdata[62:0], m_tuser);
				end else begin
					want = answers_q.pop_front();
					if (m_tdata[62:0] !== want.trips || m_tuser !== want.status
						|| m_tdata[63] !== 1'b0) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: trips exp %0d got %0d, status exp %0d got %0d",
								want.trips, m_tdata[62:0], want.status, m_tuser);
					end
				end
			end
		end
	end

endmodule

>>> test/loop_trip_count_calc_tb.sv
`timescale 1ns / 100ps

module loop_trip_count_calc_tb;

	localparam int LATENCY = 68;
	localparam int STALL_LIMIT = 2000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;   // start_value, limit_value, limit_offset, step_size
	logic [3:0]   s_tuser = '0;   // kind
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;        // trip_total
	logic [1:0]   m_tuser;        // status
	int           fail_count, pending;
	bit           long_hold = 1'b0;
	int           idle_cycles = 0;

	always #1 clk = ~clk;

	loop_trip_count_calc i_dut (.*);

	loop_trip_count_calc_chk i_chk (.*);

	// random 64-bit word, biased toward the interesting edges
	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'(signed'($urandom_range(0, 40)) - 20);
			3, 4: return 64'(signed'($urandom_range(0, 2000)) - 1000);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [62:0] pick_step();
		case ($urandom_range(0, 5))
			0: return 63'd1;
			1: return {63{1'b1}};
			2: return 63'($urandom_range(1, 16));
			3: return 63'($urandom_range(1, 300));
			default: return 63'({$urandom, $urandom});
		endcase
	endfunction

	// one source beat, waits for the handshake; valid stays up for a beat that follows
	task automatic send_query(logic [63:0] lo, logic [63:0] hi, logic [63:0] offs,
		logic [62:0] stp, logic [3:0] k, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {1'b0, stp, offs, hi, lo};
		s_tuser  <= k;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// sink: random stalls, plus one long hold-off while the source keeps pushing
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// watchdog: cycles with no beat accepted on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("loop_trip_count_calc_tb: errors");
			$finish;
		end
	end

	initial begin
		int gap;
		logic [63:0] base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, unknown kinds, zero step, extremes
		for (int k = 0; k < 16; k++)
			send_query(64'd0, 64'd10, 64'd0, 63'd3, 4'(k), 0);
		send_query(64'd0, 64'd10, 64'd0, 63'd0, 4'd0, 0);                // zero step
		send_query(64'd5, 64'd0, 64'h8000_0000_0000_0000, 63'd1, 4'd2, 0); // negate min
		send_query(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'd0, 63'd1, 4'd0, 0);
		send_query(64'd7, 64'd7, 64'd0, 63'd1, 4'd1, 0);                   // empty-ish
		send_query(64'd9, 64'd3, 64'd0, 63'd1, 4'd0, 0);                   // negative span
		send_query(64'd0, 64'h7fff_ffff_ffff_ffff, 64'd0, {63{1'b1}}, 4'd0, 0);
		send_query(64'd0, 64'h7fff_ffff_ffff_ffff, 64'd0, 63'd2, 4'd0, 0); // rounding ovf
		send_query(64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_fffe, 64'd0, 63'd1, 4'd1, 0);
		send_query(64'd0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, {63{1'b1}},
			4'hf, 0);

		// random; burst with a long sink hold-off, and one drain pause mid-way
		for (int n = 0; n < 850; n++) begin
			if (n == 100) long_hold = 1'b1;
			if (n == 500) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
			end
			gap = (n >= 100 && n < 200) ? 0 : $urandom_range(0, 17);
			if (n % 3 == 0) gap = 0;
			if ($urandom_range(0, 9) < 7) begin
				base = pick_word();
				send_query(base, base + 64'(signed'($urandom_range(0, 4000)) - 500),
					64'(signed'($urandom_range(0, 20)) - 10), pick_step(),
					4'($urandom_range(0, 7)), gap);
			end else begin
				send_query(pick_word(), pick_word(), pick_word(), pick_step(),
					4'($urandom_range(0, 15)), gap);
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("loop_trip_count_calc_tb: clean");
		else
			$display("loop_trip_count_calc_tb: errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/ltc_pkg.sv
sv/ltc_prep.sv
sv/ltc_div.sv
sv/loop_trip_count_calc.sv
test/loop_trip_count_calc_chk.sv
test/loop_trip_count_calc_tb.sv
